// File: rtl/core/spe_pkg.sv
package spe_pkg;

	localparam int unsigned MAX_DEGREE = 255;

	localparam int unsigned X_W     = 32;
	localparam int unsigned COEF_W  = 32;
	localparam int unsigned EXP_W   = 8;
	localparam int unsigned PROD_W  = 64;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;

	localparam logic [ADDR_W-1:0] X_VALUE_ADDR = 3'd0;

	localparam logic signed [X_W-1:0] ONE_Q16   = 32'sh0001_0000;
	localparam logic signed [X_W-1:0] Q16_MAX   = 32'sh7fff_ffff;
	localparam logic signed [X_W-1:0] Q16_MIN   = 32'sh8000_0000;
	localparam logic signed [PROD_W-1:0] ACC_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [PROD_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;

	// Q16.16 power as reduced from the registered product
	typedef struct packed {
		logic                   ovf;
		logic signed [X_W-1:0]  value;
	} pow_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_POW  = 5'b00010,
		ST_COEF = 5'b00100,
		ST_ACC  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

endpackage

// File: rtl/core/sparse_polynomial_evaluate.sv
// Sparse polynomial evaluator. Each input transaction carries one term (integer
// coefficient, exponent, last-term flag); the block raises the Q16.16 point
// x_value (APB register at address 0) to the exponent, clamped to MAX_DEGREE,
// by repeated multiplication from 1.0, flooring and saturating each product to
// 32 bits, then multiplies by the coefficient and adds into a saturating Q47.16
// accumulator. On the last term the sum and a sticky saturation flag go out as
// one output transaction and the accumulator clears. A single 32x32 multiplier
// does all the work, one product per cycle while in the power and coefficient
// steps; the accumulate step follows, and on the last term the emit step loads
// the output register once it is empty or being read. Input is taken again
// while a result waits in the output register.
module sparse_polynomial_evaluate (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [spe_pkg::ADDR_W-1:0]           paddr,
	input  logic [spe_pkg::DATA_W-1:0]           pwdata,
	output logic [spe_pkg::DATA_W-1:0]           prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [spe_pkg::COEF_W-1:0]    coefficient,
	input  logic [spe_pkg::EXP_W-1:0]            exponent,
	input  logic                                 last_term,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [spe_pkg::PROD_W-1:0]    poly_value,
	output logic                                 saturated
);
	import spe_pkg::*;

	state_t                    state_q;
	logic signed [X_W-1:0]     x_q;
	logic signed [COEF_W-1:0]  coef_q;
	logic [EXP_W-1:0]          cnt_q;
	logic                      last_q;
	logic                      first_q;
	logic signed [PROD_W-1:0]  acc_q;
	logic                      ovf_q;
	logic                      out_valid_q;
	logic signed [PROD_W-1:0]  poly_value_q;
	logic                      saturated_q;

	logic [EXP_W-1:0]          eff_exp;
	logic                      mul_en;
	logic signed [X_W-1:0]     mul_a;
	logic signed [X_W-1:0]     mul_b;
	logic signed [PROD_W-1:0]  prod;
	pow_t                      pow;
	logic                      pow_ovf;
	logic [PROD_W:0]           sum;
	logic                      sum_ovf;
	logic signed [PROD_W-1:0]  sum_sat;
	logic                      emit_load;
	logic                      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == X_VALUE_ADDR);
	assign prdata = (paddr == X_VALUE_ADDR) ? x_q : '0;

	assign eff_exp = (32'(exponent) > MAX_DEGREE) ? EXP_W'(MAX_DEGREE) : exponent;

	assign in_ready = (state_q == ST_IDLE);

	// first step starts from 1.0, later steps chain off the registered product
	assign mul_a   = first_q ? ONE_Q16 : pow.value;
	assign pow_ovf = !first_q && pow.ovf;
	assign mul_b   = (state_q == ST_COEF) ? coef_q : x_q;
	assign mul_en  = (state_q == ST_POW) || (state_q == ST_COEF);

	spe_mul_unit u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod),
		.pow  (pow)
	);

	assign sum     = {acc_q[PROD_W-1], acc_q} + {prod[PROD_W-1], prod};
	assign sum_ovf = sum[PROD_W] != sum[PROD_W-1];
	assign sum_sat = sum_ovf ? (sum[PROD_W] ? ACC_MIN : ACC_MAX) : sum[PROD_W-1:0];

	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
		end else if (cfg_wr) begin
			x_q <= pwdata[X_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			first_q <= 1'b1;
			cnt_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						first_q <= 1'b1;
						cnt_q   <= eff_exp;
						last_q  <= last_term;
						state_q <= (eff_exp != '0) ? ST_POW : ST_COEF;
					end
				end
				ST_POW: begin
					first_q <= 1'b0;
					ovf_q   <= ovf_q | pow_ovf;
					cnt_q   <= cnt_q - 1'b1;
					if (cnt_q == EXP_W'(1)) begin
						state_q <= ST_COEF;
					end
				end
				ST_COEF: begin
					ovf_q   <= ovf_q | pow_ovf;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					acc_q   <= sum_sat;
					ovf_q   <= ovf_q | sum_ovf;
					state_q <= last_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (emit_load) begin
						acc_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			coef_q <= coefficient;
		end
		if (emit_load) begin
			poly_value_q <= acc_q;
			saturated_q  <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign poly_value = poly_value_q;
	assign saturated  = saturated_q;

endmodule

// File: rtl/core/spe_mul_unit.sv
module spe_mul_unit (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [spe_pkg::X_W-1:0]      a,
	input  logic signed [spe_pkg::X_W-1:0]      b,
	output logic signed [spe_pkg::PROD_W-1:0]   prod,
	output spe_pkg::pow_t                       pow
);
	import spe_pkg::*;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] shifted;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

	assign prod = prod_q;

	// arithmetic shift gives the floor; the result fits 32 bits iff bits 63:47 agree
	assign shifted = prod_q >>> 16;

	always_comb begin
		pow.ovf   = !((&prod_q[PROD_W-1:47]) || !(|prod_q[PROD_W-1:47]));
		pow.value = shifted[X_W-1:0];
		if (pow.ovf) begin
			pow.value = prod_q[PROD_W-1] ? Q16_MIN : Q16_MAX;
		end
	end

endmodule
